[src/fat_boot_sector_validator_top_macros.svh]
// Assertion macros for the FAT boot-sector validator.
`ifndef FAT_BOOT_SECTOR_VALIDATOR_TOP_MACROS_SVH
`define FAT_BOOT_SECTOR_VALIDATOR_TOP_MACROS_SVH

// Checked outside reset only.
`define FBV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FBV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/fbv_pkg.sv]
// Shared types, status codes and limits of the FAT boot-sector validator.
package fbv_pkg;

    // Status codes, first failed check wins
    localparam logic [4:0] ST_OK           = 5'd0;
    localparam logic [4:0] ST_SIGNATURE    = 5'd1;
    localparam logic [4:0] ST_SECTOR_SIZE  = 5'd2;
    localparam logic [4:0] ST_CLUSTER_POW2 = 5'd3;
    localparam logic [4:0] ST_CLUSTER_BIG  = 5'd4;
    localparam logic [4:0] ST_RESERVED     = 5'd5;
    localparam logic [4:0] ST_COPIES       = 5'd6;
    localparam logic [4:0] ST_TABLE_SIZE   = 5'd7;
    localparam logic [4:0] ST_TOTAL        = 5'd8;
    localparam logic [4:0] ST_META_OVF     = 5'd9;
    localparam logic [4:0] ST_META_FIT     = 5'd10;
    localparam logic [4:0] ST_NO_CLUSTERS  = 5'd11;
    localparam logic [4:0] ST_LEG_RESERVED = 5'd12;
    localparam logic [4:0] ST_LEG_ROOT_AL  = 5'd13;
    localparam logic [4:0] ST_LEG_ROOT_0   = 5'd14;
    localparam logic [4:0] ST_F32_ROOT     = 5'd15;
    localparam logic [4:0] ST_F32_TOT16    = 5'd16;
    localparam logic [4:0] ST_F32_FSZ16    = 5'd17;

    // FAT kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_FAT12 = 2'd1;
    localparam logic [1:0] KIND_FAT16 = 2'd2;
    localparam logic [1:0] KIND_FAT32 = 2'd3;

    // Limits
    localparam logic [15:0] SIG_GOOD    = 16'hAA55;
    localparam logic [31:0] FAT12_LIMIT = 32'd4085;
    localparam logic [31:0] FAT16_LIMIT = 32'd65525;
    // log2 of the largest cluster in bytes (32 KiB)
    localparam int          CLUSTER_MAX_LOG2 = 15;
    // log2 of the smallest sector size (512)
    localparam int          SECTOR_MIN_LOG2  = 9;

    typedef struct packed {
        logic [15:0] boot_signature;
        logic [15:0] sector_bytes;
        logic [7:0]  cluster_sectors;
        logic [15:0] reserved_count;
        logic [7:0]  table_copies;
        logic [15:0] root_entries;
        logic [15:0] table_size_short;
        logic [31:0] table_size_long;
        logic [15:0] total_short;
        logic [31:0] total_long;
    } bpb_t;

    typedef struct packed {
        logic [4:0]  status;
        logic [1:0]  fat_kind;
        logic [12:0] sector_size_out;
        logic [7:0]  cluster_size_out;
    } result_t;

endpackage

[src/fbv_bpb_if.sv]
// Input channel: parsed boot-sector fields of one volume per item.
interface fbv_bpb_if import fbv_pkg::*; ();
    logic valid;
    logic ready;
    bpb_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/fbv_result_if.sv]
// Output channel: one validation result per item.
interface fbv_result_if import fbv_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/fat_boot_sector_validator_top.sv]
// FAT boot-sector validator: five-stage pipeline from parsed fields to status and FAT kind.
//
// Takes one item per clock unless the result side stalls and answers each with one result
// via the stages (decode, FAT-area multiply, metadata sum, data-sector subtract, classify),
// in order. Stages hold their own valid bits; when the result side stalls the
// pipeline fills up and then holds, and bpb.ready follows combinationally from
// result.ready through the stage chain. The 8x32 FAT-area multiply, the metadata
// add and the data-sector subtract each own a stage. The block keeps no state
// between items.
`include "fat_boot_sector_validator_top_macros.svh"

module fat_boot_sector_validator_top import fbv_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    fbv_bpb_if.sink      bpb,
    fbv_result_if.source result
);

    // Stage payloads
    typedef struct packed {
        logic [4:0]  st;
        logic [7:0]  nfat;
        logic [31:0] fsz;
        logic [15:0] rsv;
        logic [12:0] rootsec;
        logic [31:0] tot;
        logic [2:0]  l2;
        logic [12:0] bps;
        logic [7:0]  spc;
        logic        rsv_one;
        logic        root_mis;
        logic        root_zero;
        logic        tot16_nz;
        logic        fsz16_nz;
    } s1_t;

    typedef struct packed {
        logic [4:0]  st;
        logic [39:0] prod;
        logic [16:0] small_sum;
        logic [31:0] tot;
        logic [2:0]  l2;
        logic [12:0] bps;
        logic [7:0]  spc;
        logic        rsv_one;
        logic        root_mis;
        logic        root_zero;
        logic        tot16_nz;
        logic        fsz16_nz;
    } s2_t;

    typedef struct packed {
        logic [4:0]  st;
        logic [31:0] meta;
        logic [31:0] tot;
        logic [2:0]  l2;
        logic [12:0] bps;
        logic [7:0]  spc;
        logic        rsv_one;
        logic        root_mis;
        logic        root_zero;
        logic        tot16_nz;
        logic        fsz16_nz;
    } s3_t;

    typedef struct packed {
        logic [4:0]  st;
        logic [31:0] data_sec;
        logic [2:0]  l2;
        logic [12:0] bps;
        logic [7:0]  spc;
        logic        rsv_one;
        logic        root_mis;
        logic        root_zero;
        logic        tot16_nz;
        logic        fsz16_nz;
    } s4_t;

    s1_t     s1_reg, s1_next;
    s2_t     s2_reg, s2_next;
    s3_t     s3_reg, s3_next;
    s4_t     s4_reg, s4_next;
    result_t s5_reg, s5_next;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    // Terms for the checks
    logic res_ok;
    logic res_cleared;
    logic res_sized;
    logic pipe_full;

    // Stage advance: a stage loads when it is empty or its contents move on
    assign en5 = !v5_reg || result.ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign bpb.ready    = en1;
    assign result.valid = v5_reg;
    assign result.data  = s5_reg;

    // Stage 1: field checks, size decode, root-directory sectors
    always_comb
    begin
        logic [1:0]  ks;
        logic        bps_ok;
        logic        spc_pow2;
        logic [21:0] root_sum;
        logic [15:0] root_mask;
        logic [3:0]  shift;
        bpb_t        d;

        d = bpb.data;
        bps_ok = 1'b1;
        ks = 2'd0;
        case (d.sector_bytes)
            16'd512:  ks = 2'd0;
            16'd1024: ks = 2'd1;
            16'd2048: ks = 2'd2;
            16'd4096: ks = 2'd3;
            default:  bps_ok = 1'b0;
        endcase
        // root bytes a multiple of the sector size: low entry bits all zero
        root_mask = (16'h0010 << ks) - 16'd1;

        spc_pow2 = (d.cluster_sectors != 8'd0)
                && ((d.cluster_sectors & (d.cluster_sectors - 8'd1)) == 8'd0);
        s1_next.l2 = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (d.cluster_sectors[i])
                s1_next.l2 = 3'(i);
        end

        // ceil(entries * 32 / bytes per sector), divisor a power of two
        root_sum = {1'b0, d.root_entries, 5'd0} + {6'd0, d.sector_bytes} - 22'd1;
        shift = 4'(SECTOR_MIN_LOG2) + {2'd0, ks};
        s1_next.rootsec = 13'(root_sum >> shift);

        s1_next.fsz = (d.table_size_short != 16'd0) ? {16'd0, d.table_size_short}
                                                    : d.table_size_long;
        s1_next.tot = (d.total_short != 16'd0) ? {16'd0, d.total_short} : d.total_long;

        // First failed check sets the status
        if (d.boot_signature != SIG_GOOD)
            s1_next.st = ST_SIGNATURE;
        else if (!bps_ok)
            s1_next.st = ST_SECTOR_SIZE;
        else if (!spc_pow2)
            s1_next.st = ST_CLUSTER_POW2;
        else if ({2'd0, ks} + {1'b0, s1_next.l2} > 4'(CLUSTER_MAX_LOG2 - SECTOR_MIN_LOG2))
            s1_next.st = ST_CLUSTER_BIG;
        else if (d.reserved_count == 16'd0)
            s1_next.st = ST_RESERVED;
        else if (d.table_copies == 8'd0)
            s1_next.st = ST_COPIES;
        else if (s1_next.fsz == 32'd0)
            s1_next.st = ST_TABLE_SIZE;
        else if (s1_next.tot == 32'd0)
            s1_next.st = ST_TOTAL;
        else
            s1_next.st = ST_OK;

        s1_next.nfat      = d.table_copies;
        s1_next.rsv       = d.reserved_count;
        s1_next.bps       = d.sector_bytes[12:0];
        s1_next.spc       = d.cluster_sectors;
        s1_next.rsv_one   = (d.reserved_count == 16'd1);
        s1_next.root_mis  = ((d.root_entries & root_mask) != 16'd0);
        s1_next.root_zero = (d.root_entries == 16'd0);
        s1_next.tot16_nz  = (d.total_short != 16'd0);
        s1_next.fsz16_nz  = (d.table_size_short != 16'd0);
    end

    // Stage 2: FAT area and the small addends
    always_comb
    begin
        s2_next.st        = s1_reg.st;
        s2_next.prod      = {32'd0, s1_reg.nfat} * {8'd0, s1_reg.fsz};
        s2_next.small_sum = {1'b0, s1_reg.rsv} + {4'd0, s1_reg.rootsec};
        s2_next.tot       = s1_reg.tot;
        s2_next.l2        = s1_reg.l2;
        s2_next.bps       = s1_reg.bps;
        s2_next.spc       = s1_reg.spc;
        s2_next.rsv_one   = s1_reg.rsv_one;
        s2_next.root_mis  = s1_reg.root_mis;
        s2_next.root_zero = s1_reg.root_zero;
        s2_next.tot16_nz  = s1_reg.tot16_nz;
        s2_next.fsz16_nz  = s1_reg.fsz16_nz;
    end

    // Stage 3: metadata sum; all addends positive, so one final range check
    always_comb
    begin
        logic [40:0] meta_full;

        meta_full = {1'b0, s2_reg.prod} + {24'd0, s2_reg.small_sum};
        s3_next.st = s2_reg.st;
        if (s2_reg.st == ST_OK && meta_full[40:32] != 9'd0)
            s3_next.st = ST_META_OVF;
        s3_next.meta      = meta_full[31:0];
        s3_next.tot       = s2_reg.tot;
        s3_next.l2        = s2_reg.l2;
        s3_next.bps       = s2_reg.bps;
        s3_next.spc       = s2_reg.spc;
        s3_next.rsv_one   = s2_reg.rsv_one;
        s3_next.root_mis  = s2_reg.root_mis;
        s3_next.root_zero = s2_reg.root_zero;
        s3_next.tot16_nz  = s2_reg.tot16_nz;
        s3_next.fsz16_nz  = s2_reg.fsz16_nz;
    end

    // Stage 4: data sectors, at least two needed
    always_comb
    begin
        logic [32:0] diff;

        diff = {1'b0, s3_reg.tot} - {1'b0, s3_reg.meta};
        s4_next.st = s3_reg.st;
        if (s3_reg.st == ST_OK && (diff[32] || diff[31:1] == 31'd0))
            s4_next.st = ST_META_FIT;
        s4_next.data_sec  = diff[31:0];
        s4_next.l2        = s3_reg.l2;
        s4_next.bps       = s3_reg.bps;
        s4_next.spc       = s3_reg.spc;
        s4_next.rsv_one   = s3_reg.rsv_one;
        s4_next.root_mis  = s3_reg.root_mis;
        s4_next.root_zero = s3_reg.root_zero;
        s4_next.tot16_nz  = s3_reg.tot16_nz;
        s4_next.fsz16_nz  = s3_reg.fsz16_nz;
    end

    // Stage 5: cluster count, kind and kind-specific rules
    always_comb
    begin
        logic [31:0] clusters;
        logic [4:0]  st;
        logic [1:0]  kind;

        clusters = s4_reg.data_sec >> s4_reg.l2;
        st = s4_reg.st;
        kind = KIND_NONE;
        if (st == ST_OK)
        begin
            if (clusters == 32'd0)
                st = ST_NO_CLUSTERS;
            else
            begin
                if (clusters < FAT12_LIMIT)
                    kind = KIND_FAT12;
                else if (clusters < FAT16_LIMIT)
                    kind = KIND_FAT16;
                else
                    kind = KIND_FAT32;

                if (kind != KIND_FAT32)
                begin
                    if (!s4_reg.rsv_one)
                        st = ST_LEG_RESERVED;
                    else if (s4_reg.root_mis)
                        st = ST_LEG_ROOT_AL;
                    else if (s4_reg.root_zero)
                        st = ST_LEG_ROOT_0;
                end
                else
                begin
                    if (!s4_reg.root_zero)
                        st = ST_F32_ROOT;
                    else if (s4_reg.tot16_nz)
                        st = ST_F32_TOT16;
                    else if (s4_reg.fsz16_nz)
                        st = ST_F32_FSZ16;
                end
            end
        end

        s5_next.status = st;
        if (st == ST_OK)
        begin
            s5_next.fat_kind         = kind;
            s5_next.sector_size_out  = s4_reg.bps;
            s5_next.cluster_size_out = s4_reg.spc;
        end
        else
        begin
            s5_next.fat_kind         = KIND_NONE;
            s5_next.sector_size_out  = 13'd0;
            s5_next.cluster_size_out = 8'd0;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= bpb.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en1) s1_reg <= s1_next;
        if (en2) s2_reg <= s2_next;
        if (en3) s3_reg <= s3_next;
        if (en4) s4_reg <= s4_next;
        if (en5) s5_reg <= s5_next;
    end

    // Checks
    assign res_ok      = (result.data.status == ST_OK);
    assign res_cleared = (result.data.fat_kind == KIND_NONE)
                      && (result.data.sector_size_out == 13'd0)
                      && (result.data.cluster_size_out == 8'd0);
    assign res_sized   = (result.data.fat_kind != KIND_NONE)
                      && (result.data.cluster_size_out != 8'd0)
                      && (result.data.sector_size_out >= 13'd512);
    assign pipe_full   = v1_reg && v2_reg && v3_reg && v4_reg && v5_reg;

    `FBV_ASSERT(a_fail_clears, result.valid && !res_ok |-> res_cleared, "kind or size on failure")
    `FBV_ASSERT(a_ok_sizes, result.valid && res_ok |-> res_sized, "good item lacks kind or size")
    `FBV_ASSERT_ALWAYS(a_full_stall, pipe_full && !result.ready |-> !bpb.ready, "accept while full")

endmodule

[verif/tb_fat_boot_sector_validator_top.sv]
// Self-checking testbench for the FAT boot-sector validator: directed table, then random volumes.
`timescale 1ns / 100ps

module tb_fat_boot_sector_validator_top;
    import fbv_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 200_000;
    localparam int unsigned ITEMS_PER_PHASE = 217;
    // pipeline is five deep; spare cycles to wait at the end
    localparam int unsigned DRAIN_CYCLES    = 12;
    localparam logic [63:0] WORD_MAX        = 64'hFFFF_FFFF;

    typedef struct {
        bpb_t    fields;
        bit      known;
        result_t verdict;
    } volume_case_t;

    logic clk;
    logic rst_n;

    fbv_bpb_if    bpb_ch ();
    fbv_result_if res_ch ();

    fat_boot_sector_validator_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bpb    (bpb_ch),
        .result (res_ch)
    );

    result_t      pending_verdicts[$];
    volume_case_t directed_cases[$];
    int unsigned  sender_gap_pct;
    int unsigned  sink_stall_pct;
    int unsigned  fault_count;
    int unsigned  volumes_sent;
    int unsigned  verdicts_checked;
    int unsigned  cycle_count;
    logic [31:0]  seen_status;
    logic [3:0]   seen_kinds;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Status and FAT kind of one boot sector, first failing check wins
    function automatic result_t validate_boot_sector(input bpb_t b);
        logic [63:0] bps, spc, rsv, copies, rootn, fat_sz, total, root_secs, meta, clusters;
        logic [1:0]  kind;
        result_t     r;
        r      = '0;
        bps    = 64'(b.sector_bytes);
        spc    = 64'(b.cluster_sectors);
        rsv    = 64'(b.reserved_count);
        copies = 64'(b.table_copies);
        rootn  = 64'(b.root_entries);
        fat_sz = (b.table_size_short != 16'd0) ? 64'(b.table_size_short)
                                               : 64'(b.table_size_long);
        total  = (b.total_short != 16'd0) ? 64'(b.total_short) : 64'(b.total_long);
        if (b.boot_signature != SIG_GOOD)
            r.status = ST_SIGNATURE;
        else if (bps != 64'd512 && bps != 64'd1024 && bps != 64'd2048 && bps != 64'd4096)
            r.status = ST_SECTOR_SIZE;
        else if (spc == 64'd0 || (spc & (spc - 64'd1)) != 64'd0)
            r.status = ST_CLUSTER_POW2;
        else if (bps * spc > (64'd1 << CLUSTER_MAX_LOG2))
            r.status = ST_CLUSTER_BIG;
        else if (rsv == 64'd0)
            r.status = ST_RESERVED;
        else if (copies == 64'd0)
            r.status = ST_COPIES;
        else if (fat_sz == 64'd0)
            r.status = ST_TABLE_SIZE;
        else if (total == 64'd0)
            r.status = ST_TOTAL;
        else
        begin
            root_secs = (rootn * 64'd32 + bps - 64'd1) / bps;
            // partial sums only grow, so the final sum tells of any 32-bit overflow
            meta = copies * fat_sz + rsv + root_secs;
            if (meta > WORD_MAX)
                r.status = ST_META_OVF;
            else if (meta > total || total - meta < 64'd2)
                r.status = ST_META_FIT;
            else
            begin
                clusters = (total - meta) / spc;
                if (clusters == 64'd0)
                    r.status = ST_NO_CLUSTERS;
                else
                begin
                    if (clusters < 64'(FAT12_LIMIT))
                        kind = KIND_FAT12;
                    else if (clusters < 64'(FAT16_LIMIT))
                        kind = KIND_FAT16;
                    else
                        kind = KIND_FAT32;
                    if (kind != KIND_FAT32)
                    begin
                        if (rsv != 64'd1)
                            r.status = ST_LEG_RESERVED;
                        else if (((rootn * 64'd32) & (bps - 64'd1)) != 64'd0)
                            r.status = ST_LEG_ROOT_AL;
                        else if (rootn == 64'd0)
                            r.status = ST_LEG_ROOT_0;
                    end
                    else
                    begin
                        if (rootn != 64'd0)
                            r.status = ST_F32_ROOT;
                        else if (b.total_short != 16'd0)
                            r.status = ST_F32_TOT16;
                        else if (b.table_size_short != 16'd0)
                            r.status = ST_F32_FSZ16;
                    end
                    if (r.status == ST_OK)
                    begin
                        r.fat_kind         = kind;
                        r.sector_size_out  = bps[12:0];
                        r.cluster_size_out = spc[7:0];
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic bpb_t boot_fields(input logic [15:0] sig, input logic [15:0] bps,
                                         input logic [7:0] spc, input logic [15:0] rsv,
                                         input logic [7:0] copies, input logic [15:0] rootn,
                                         input logic [15:0] fsz16, input logic [31:0] fsz32,
                                         input logic [15:0] tot16, input logic [31:0] tot32);
        bpb_t b;
        b.boot_signature   = sig;
        b.sector_bytes     = bps;
        b.cluster_sectors  = spc;
        b.reserved_count   = rsv;
        b.table_copies     = copies;
        b.root_entries     = rootn;
        b.table_size_short = fsz16;
        b.table_size_long  = fsz32;
        b.total_short      = tot16;
        b.total_long       = tot32;
        return b;
    endfunction

    function automatic result_t fail_with(input logic [4:0] status);
        result_t r;
        r        = '0;
        r.status = status;
        return r;
    endfunction

    // Mostly well-formed volumes of a random kind, some broken on purpose, some noise
    function automatic bpb_t random_volume();
        bpb_t         v;
        logic [191:0] noise;
        int unsigned  bps_log, spc_log, shape;
        logic [63:0]  bps, spc, fat_sz, root_secs, meta, clusters, total;
        v = '0;
        if ($urandom_range(99) < 8)
        begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            v = noise[$bits(bpb_t)-1:0];
            if ($urandom_range(1) == 1)
                v.boot_signature = SIG_GOOD;
            return v;
        end
        bps_log = $urandom_range(3);
        spc_log = $urandom_range(6 - bps_log);
        bps     = 64'd512 << bps_log;
        spc     = 64'd1 << spc_log;
        shape   = $urandom_range(2);
        v.boot_signature  = SIG_GOOD;
        v.sector_bytes    = bps[15:0];
        v.cluster_sectors = spc[7:0];
        v.table_copies    = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255))
                                                     : 8'($urandom_range(1, 2));
        if (shape == 2)
        begin
            // FAT32 layout
            v.reserved_count  = 16'($urandom_range(1, 64));
            fat_sz            = 64'($urandom_range(1, 1 << 20));
            v.table_size_long = fat_sz[31:0];
            root_secs         = 64'd0;
            clusters = ($urandom_range(4) == 0) ? 64'(FAT16_LIMIT)
                                                : 64'($urandom_range(65525, 1 << 22));
        end
        else
        begin
            // FAT12/16 layout with an aligned root directory
            v.reserved_count = 16'd1;
            v.root_entries   = 16'((bps >> 5) * 64'($urandom_range(1, 64)));
            root_secs        = 64'(v.root_entries) * 64'd32 / bps;
            fat_sz           = 64'($urandom_range(1, 512));
            if ($urandom_range(3) == 0)
                v.table_size_long = fat_sz[31:0];
            else
            begin
                v.table_size_short = fat_sz[15:0];
                v.table_size_long  = $urandom;
            end
            if (shape == 0)
                clusters = ($urandom_range(4) == 0) ? 64'(FAT12_LIMIT) - 64'd1
                                                    : 64'($urandom_range(1, 4084));
            else if ($urandom_range(4) == 0)
                clusters = ($urandom_range(1) == 1) ? 64'(FAT12_LIMIT)
                                                    : 64'(FAT16_LIMIT) - 64'd1;
            else
                clusters = 64'($urandom_range(4085, 65524));
        end
        meta  = 64'(v.reserved_count) + 64'(v.table_copies) * fat_sz + root_secs;
        total = meta + clusters * spc + 64'($urandom_range(0, (1 << spc_log) - 1));
        if (total > WORD_MAX)
            total = WORD_MAX;
        if (shape != 2 && total <= 64'hFFFF && $urandom_range(1) == 1)
        begin
            v.total_short = total[15:0];
            v.total_long  = $urandom;
        end
        else
            v.total_long = total[31:0];

        // break one rule now and then
        if ($urandom_range(99) < 30)
        begin
            case ($urandom_range(15))
                0: v.boot_signature = 16'($urandom);
                1: v.sector_bytes = v.sector_bytes ^ (16'd1 << $urandom_range(15));
                2: v.cluster_sectors = 8'($urandom);
                3: v.cluster_sectors = 8'd1 << (7 - bps_log);
                4: v.reserved_count = '0;
                5: v.table_copies = '0;
                6:
                begin
                    v.table_size_short = '0;
                    v.table_size_long  = '0;
                end
                7:
                begin
                    v.total_short = '0;
                    v.total_long  = '0;
                end
                8:
                begin
                    v.table_copies     = 8'($urandom_range(2, 255));
                    v.table_size_short = '0;
                    v.table_size_long  = $urandom | 32'h8000_0000;
                end
                9:
                begin
                    v.total_short = '0;
                    v.total_long  = 32'(meta + 64'd1 - 64'($urandom_range(0, 3)));
                end
                10:
                begin
                    v.total_short = '0;
                    v.total_long  = 32'(meta + 64'($urandom_range(2, (1 << spc_log) + 1)));
                end
                11: v.reserved_count = 16'($urandom_range(2, 65535));
                12: v.root_entries = v.root_entries + 16'd1;
                13: v.root_entries = '0;
                14:
                begin
                    // tiny metadata so a 16-bit total still yields a FAT32 count
                    v.cluster_sectors  = 8'd1;
                    v.reserved_count   = 16'($urandom_range(1, 3));
                    v.table_copies     = 8'd1;
                    v.table_size_short = '0;
                    v.table_size_long  = 32'($urandom_range(1, 3));
                    v.root_entries     = '0;
                    v.total_short      = 16'($urandom_range(65531, 65535));
                end
                default: v.table_size_short = 16'($urandom_range(1, 65535));
            endcase
        end
        return v;
    endfunction

    task automatic add_case(input bpb_t fields, input bit known, input result_t verdict);
        directed_cases.push_back('{fields, known, verdict});
    endtask

    // Offer one volume, idling first at random; queue its verdict once taken
    task automatic send_volume(input bpb_t v, input bit known, input result_t verdict);
        result_t want;
        while ($urandom_range(99) < sender_gap_pct)
        begin
            bpb_ch.valid <= 1'b0;
            @(posedge clk);
        end
        bpb_ch.valid <= 1'b1;
        bpb_ch.data  <= v;
        do
            @(posedge clk);
        while (!bpb_ch.ready);
        want = known ? verdict : validate_boot_sector(v);
        pending_verdicts.push_back(want);
        seen_status[want.status] = 1'b1;
        seen_kinds[want.fat_kind] = 1'b1;
        volumes_sent++;
    endtask

    task automatic report_fault(input string what, input result_t want, input result_t got);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s: want status %0d kind %0d sector %0d cluster %0d, got %0d %0d %0d %0d",
                     $realtime, what, want.status, want.fat_kind, want.sector_size_out,
                     want.cluster_size_out, got.status, got.fat_kind, got.sector_size_out,
                     got.cluster_size_out);
    endtask

    // Receiver back-pressure
    always @(posedge clk)
    begin
        result_ready_drive: res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_verdicts.size() == 0)
                report_fault("result with no volume outstanding", '0, res_ch.data);
            else
            begin
                want = pending_verdicts.pop_front();
                verdicts_checked++;
                if (res_ch.data.status != want.status
                    || res_ch.data.fat_kind != want.fat_kind
                    || res_ch.data.sector_size_out != want.sector_size_out
                    || res_ch.data.cluster_size_out != want.cluster_size_out)
                    report_fault("verdict mismatch", want, res_ch.data);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d verdicts outstanding",
                     cycle_count, pending_verdicts.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        bpb_t base12, base32, v;
        clk              = 1'b0;
        rst_n            = 1'b0;
        bpb_ch.valid     = 1'b0;
        bpb_ch.data      = '0;
        res_ch.ready     = 1'b0;
        sender_gap_pct   = 6;
        sink_stall_pct   = 51;
        fault_count      = 0;
        volumes_sent     = 0;
        verdicts_checked = 0;
        cycle_count      = 0;
        seen_status      = '0;
        seen_kinds       = '0;

        // Directed table: smallest valid FAT12 and a FAT32 volume as templates
        base12 = boot_fields(SIG_GOOD, 16'd512, 8'd1, 16'd1, 8'd2, 16'd16,
                             16'd1, 32'd0, 16'd6, 32'd0);
        base32 = boot_fields(SIG_GOOD, 16'd512, 8'd1, 16'd32, 8'd2, 16'd0,
                             16'd0, 32'd1000, 16'd0, 32'd102032);
        add_case('0, 1'b1, fail_with(ST_SIGNATURE));
        add_case('1, 1'b1, fail_with(ST_SIGNATURE));
        v = base12; v.sector_bytes = 16'd0;
        add_case(v, 1'b1, fail_with(ST_SECTOR_SIZE));
        v = base12; v.sector_bytes = 16'hFFFF;
        add_case(v, 1'b1, fail_with(ST_SECTOR_SIZE));
        v = base12; v.cluster_sectors = 8'd0;
        add_case(v, 1'b1, fail_with(ST_CLUSTER_POW2));
        v = base12; v.cluster_sectors = 8'hFF;
        add_case(v, 1'b1, fail_with(ST_CLUSTER_POW2));
        // 512 x 128 is a 64 KiB cluster
        v = base12; v.cluster_sectors = 8'd128;
        add_case(v, 1'b1, fail_with(ST_CLUSTER_BIG));
        v = base12; v.reserved_count = 16'd0;
        add_case(v, 1'b1, fail_with(ST_RESERVED));
        v = base12; v.table_copies = 8'd0;
        add_case(v, 1'b1, fail_with(ST_COPIES));
        v = base12; v.table_size_short = 16'd0;
        add_case(v, 1'b1, fail_with(ST_TABLE_SIZE));
        v = base12; v.total_short = 16'd0;
        add_case(v, 1'b1, fail_with(ST_TOTAL));
        // overflow in the multiply, in the reserved add and in the root add
        v = base12; v.table_copies = 8'hFF; v.table_size_short = 16'd0;
        v.table_size_long = 32'hFFFF_FFFF;
        add_case(v, 1'b1, fail_with(ST_META_OVF));
        v = base12; v.table_copies = 8'd1; v.table_size_short = 16'd0;
        v.table_size_long = 32'hFFFF_FFFF;
        add_case(v, 1'b1, fail_with(ST_META_OVF));
        v = base12; v.table_copies = 8'd1; v.table_size_short = 16'd0;
        v.table_size_long = 32'hFFFF_FFFE;
        add_case(v, 1'b1, fail_with(ST_META_OVF));
        // one data sector only
        v = base12; v.total_short = 16'd5;
        add_case(v, 1'b1, fail_with(ST_META_FIT));
        v = base12; v.cluster_sectors = 8'd4;
        add_case(v, 1'b1, fail_with(ST_NO_CLUSTERS));
        add_case(base12, 1'b1, '{ST_OK, KIND_FAT12, 13'd512, 8'd1});
        v = base12; v.reserved_count = 16'd2; v.total_short = 16'd7;
        add_case(v, 1'b1, fail_with(ST_LEG_RESERVED));
        v = base12; v.root_entries = 16'd1;
        add_case(v, 1'b1, fail_with(ST_LEG_ROOT_AL));
        v = base12; v.root_entries = 16'd0;
        add_case(v, 1'b1, fail_with(ST_LEG_ROOT_0));
        // FAT12/16 boundary and the largest FAT16 count via the 32-bit total
        v = base12; v.total_short = 16'd4089;
        add_case(v, 1'b0, '0);
        v = base12; v.total_short = 16'd0; v.total_long = 32'd65528;
        add_case(v, 1'b0, '0);
        add_case(boot_fields(SIG_GOOD, 16'd4096, 8'd8, 16'd1, 8'd2, 16'd128,
                             16'd1, 32'd0, 16'd0, 32'd804),
                 1'b1, '{ST_OK, KIND_FAT12, 13'd4096, 8'd8});
        add_case(base32, 1'b1, '{ST_OK, KIND_FAT32, 13'd512, 8'd1});
        v = base32; v.root_entries = 16'd16;
        add_case(v, 1'b1, fail_with(ST_F32_ROOT));
        add_case(boot_fields(SIG_GOOD, 16'd512, 8'd1, 16'd1, 8'd1, 16'd0,
                             16'd0, 32'd1, 16'hFFFF, 32'd0),
                 1'b1, fail_with(ST_F32_TOT16));
        v = base32; v.table_size_short = 16'd1000;
        add_case(v, 1'b1, fail_with(ST_F32_FSZ16));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cases[i])
            send_volume(directed_cases[i].fields, directed_cases[i].known,
                        directed_cases[i].verdict);

        // Random volumes under three idling patterns
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_gap_pct = 6;
                    sink_stall_pct = 51;
                end
                1:
                begin
                    sender_gap_pct = 51;
                    sink_stall_pct = 6;
                end
                default:
                begin
                    sender_gap_pct = 0;
                    sink_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_volume(random_volume(), 1'b0, '0);
        end
        bpb_ch.valid <= 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_verdicts.size() != 0)
        begin
            fault_count += pending_verdicts.size();
            $display("%0d verdicts never arrived", pending_verdicts.size());
        end

        $display("Validated %0d boot sectors, %0d verdicts compared, %0d faults",
                 volumes_sent, verdicts_checked, fault_count);
        $display("Status codes reached %0d of 18, FAT kinds reached mask %b",
                 $countones(seen_status), seen_kinds);
        if (fault_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
